/* hw/rtl/psg_tone_noise_generator_assert.svh */
// assertion macros for the tone and noise generator
`ifndef PSG_TONE_NOISE_GENERATOR_ASSERT_SVH
`define PSG_TONE_NOISE_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define PSG_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psg assertion failed");

// antecedent implies consequent in the next cycle
`define PSG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psg assertion failed");

`else

`define PSG_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define PSG_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/psg_pkg.sv */
// shared types and constants of the tone and noise generator
package psg_pkg;

   localparam int RATE_W    = 32;
   localparam int PERIOD_W  = 10;
   localparam int SAMPLE_W  = 8;
   localparam int NOISE_W   = 6;
   localparam int DIV_STEPS = RATE_W;

   localparam logic [RATE_W-1:0]   RATE_RESET   = 32'h512b_3400;
   localparam logic [NOISE_W-1:0]  NOISE_RELOAD = 6'h1f;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [1:0] TONE2_CH = 2'd2;
   localparam logic [1:0] NOISE_CH = 2'd3;

   // noise rate codes
   localparam logic [1:0] NOISE_RATE_16     = 2'd0;
   localparam logic [1:0] NOISE_RATE_32     = 2'd1;
   localparam logic [1:0] NOISE_RATE_64     = 2'd2;
   localparam logic [1:0] NOISE_RATE_FOLLOW = 2'd3;

   localparam logic [PERIOD_W-1:0] NOISE_PERIOD_16 = 10'd16;
   localparam logic [PERIOD_W-1:0] NOISE_PERIOD_32 = 10'd32;
   localparam logic [PERIOD_W-1:0] NOISE_PERIOD_64 = 10'd64;

   typedef struct packed {
      logic       opcode;
      logic [7:0] command_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] tone0_sample;
      logic [SAMPLE_W-1:0] tone1_sample;
      logic [SAMPLE_W-1:0] tone2_sample;
      logic [SAMPLE_W-1:0] noise_sample;
   } rsp_type;

   typedef struct packed {
      logic tick;
      logic write;
      logic div_start;
      logic step_load;
   } psg_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic needs_div;
      logic div_done;
   } psg_status_type;

endpackage

/* hw/rtl/psg_divider.sv */
// restoring divider, one quotient bit per cycle
module psg_divider
   import psg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [RATE_W-1:0]   dividend,
   input  logic [PERIOD_W-1:0] divisor,
   output logic                done,
   output logic [RATE_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(DIV_STEPS + 1);

   logic [CNT_W-1:0]    count_ff, count_in;
   logic                done_ff, done_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [PERIOD_W-1:0] divisor_ff, divisor_in;
   logic [RATE_W-1:0]   quot_ff, quot_in;
   logic [PERIOD_W:0]   trial;
   logic                fits;

   // trial subtraction of the shifted remainder
   assign trial = {rem_ff, quot_ff[RATE_W-1]};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      count_in   = count_ff;
      done_in    = 1'b0;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quot_in    = quot_ff;
      if (start) begin
         count_in   = CNT_W'(DIV_STEPS);
         rem_in     = '0;
         divisor_in = divisor;
         quot_in    = dividend;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == CNT_W'(1));
         rem_in   = fits ? PERIOD_W'(trial - {1'b0, divisor_ff}) : trial[PERIOD_W-1:0];
         quot_in  = {quot_ff[RATE_W-2:0], fits};
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quot_ff    <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

/* hw/rtl/psg_datapath.sv */
// channel registers, phase accumulators, noise register and step divider
module psg_datapath
   import psg_pkg::*;
#(
   parameter int PHASE_BITS = 29
) (
   input  logic                clock,
   input  logic                reset,
   input  req_type             req_payload,
   input  logic                csr_wr_en,
   input  logic [RATE_W-1:0]   csr_wr_data,
   input  psg_cmd_type         cmd,
   output psg_status_type      status,
   output rsp_type             rsp_payload
);

   localparam int SUM_W = RATE_W + 1;

   logic [SAMPLE_W-1:0]   vol_ff   [4], vol_in   [4];
   logic [3:0]            nib_ff   [4], nib_in   [4];
   logic [5:0]            high_ff  [4], high_in  [4];
   logic [PHASE_BITS-1:0] acc_ff   [4], acc_in   [4];
   logic [RATE_W-1:0]     step_ff  [4], step_in  [4];
   logic [NOISE_W-1:0]    shift_ff, shift_in;
   logic [1:0]            latched_ff, latched_in;
   logic [1:0]            target_ff, target_in;
   logic [RATE_W-1:0]     rate_ff, rate_in;
   logic                  period_zero_ff, period_zero_in;
   rsp_type               rsp_ff, rsp_in;

   logic [PHASE_BITS-1:0] tone_sum [3];
   logic [SUM_W-1:0]      noise_sum;
   logic                  noise_ovf;
   logic [NOISE_W-1:0]    shift_pre, shift_post;
   logic                  noise_fb;
   logic                  follow2;
   logic [PERIOD_W-1:0]   noise_period, div_period;
   logic [RATE_W-1:0]     quotient;
   logic                  div_done;
   logic [7:0]            cmd_byte;

   assign cmd_byte = req_payload.command_byte;

   // decode for the controller
   assign status.is_tick   = (req_payload.opcode == OP_TICK);
   assign status.needs_div = !(cmd_byte[7] && cmd_byte[4]);
   assign status.div_done  = div_done;

   // period selection for the divider
   assign follow2 = (nib_ff[NOISE_CH][1:0] == NOISE_RATE_FOLLOW);
   always_comb begin
      case (nib_ff[NOISE_CH][1:0])
         NOISE_RATE_16: noise_period = NOISE_PERIOD_16;
         NOISE_RATE_32: noise_period = NOISE_PERIOD_32;
         NOISE_RATE_64: noise_period = NOISE_PERIOD_64;
         default:       noise_period = {high_ff[TONE2_CH], nib_ff[TONE2_CH]};
      endcase
   end
   assign div_period = (target_ff == NOISE_CH) ? noise_period
                                               : {high_ff[target_ff], nib_ff[target_ff]};

   psg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (rate_ff),
      .divisor  (div_period),
      .done     (div_done),
      .quotient (quotient)
   );

   // accumulator sums and noise clocking
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tone_sum[i] = acc_ff[i] + step_ff[i][PHASE_BITS-1:0];
      end
      noise_sum = SUM_W'(acc_ff[NOISE_CH]) + SUM_W'(step_ff[NOISE_CH]);
      noise_ovf = |noise_sum[SUM_W-1:PHASE_BITS];
      shift_pre = (req_payload.frame_start && shift_ff == '0) ? NOISE_RELOAD : shift_ff;
      noise_fb  = nib_ff[NOISE_CH][2] ? (shift_pre[0] ^ shift_pre[2]) : ~shift_pre[0];
      shift_post = noise_ovf
                 ? {1'b0, shift_pre[5] | noise_fb, shift_pre[4:1]}
                 : shift_pre;
   end

   // next state of the channel registers
   always_comb begin
      vol_in         = vol_ff;
      nib_in         = nib_ff;
      high_in        = high_ff;
      acc_in         = acc_ff;
      step_in        = step_ff;
      shift_in       = shift_ff;
      latched_in     = latched_ff;
      target_in      = target_ff;
      rate_in        = rate_ff;
      period_zero_in = period_zero_ff;
      rsp_in         = rsp_ff;

      if (csr_wr_en) begin
         rate_in = csr_wr_data;
      end

      // register write transaction
      if (cmd.write) begin
         if (cmd_byte[7]) begin
            if (cmd_byte[4]) begin
               vol_in[cmd_byte[6:5]] = {~cmd_byte[3:0], ~cmd_byte[3:0]};
            end else begin
               latched_in              = cmd_byte[6:5];
               target_in               = cmd_byte[6:5];
               nib_in[cmd_byte[6:5]]   = cmd_byte[3:0];
               if (cmd_byte[6:5] == NOISE_CH) begin
                  shift_in = NOISE_RELOAD;
               end
            end
         end else begin
            high_in[latched_ff] = cmd_byte[5:0];
            target_in           = latched_ff;
            if (latched_ff == NOISE_CH) begin
               shift_in = NOISE_RELOAD;
            end
         end
      end

      // division start
      if (cmd.div_start) begin
         period_zero_in = (div_period == '0);
      end

      // step update when the quotient is ready
      if (cmd.step_load) begin
         step_in[target_ff] = period_zero_ff ? '0 : quotient;
         if (target_ff == TONE2_CH && follow2) begin
            step_in[NOISE_CH] = period_zero_ff ? '0 : quotient;
         end
      end

      // sample tick transaction
      if (cmd.tick) begin
         for (int i = 0; i < 3; i++) begin
            acc_in[i] = tone_sum[i];
         end
         acc_in[NOISE_CH] = noise_sum[PHASE_BITS-1:0];
         shift_in         = shift_post;
         rsp_in.tone0_sample = tone_sum[0][PHASE_BITS-1] ? vol_ff[0] : '0;
         rsp_in.tone1_sample = tone_sum[1][PHASE_BITS-1] ? vol_ff[1] : '0;
         rsp_in.tone2_sample = tone_sum[2][PHASE_BITS-1] ? vol_ff[2] : '0;
         rsp_in.noise_sample = shift_post[0] ? vol_ff[NOISE_CH] : '0;
      end
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            vol_ff[i]  <= '0;
            nib_ff[i]  <= '0;
            high_ff[i] <= '0;
            acc_ff[i]  <= '0;
            step_ff[i] <= '0;
         end
         shift_ff   <= '0;
         latched_ff <= '0;
         rate_ff    <= RATE_RESET;
      end else begin
         vol_ff     <= vol_in;
         nib_ff     <= nib_in;
         high_ff    <= high_in;
         acc_ff     <= acc_in;
         step_ff    <= step_in;
         shift_ff   <= shift_in;
         latched_ff <= latched_in;
         rate_ff    <= rate_in;
      end
   end

   // working and output registers
   always_ff @(posedge clock) begin
      target_ff      <= target_in;
      period_zero_ff <= period_zero_in;
      rsp_ff         <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

endmodule

/* hw/rtl/psg_ctrl.sv */
// transaction sequencing and result handshake of the tone and noise generator
module psg_ctrl
   import psg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  psg_status_type status,
   output psg_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_DIVIDE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   // take a transaction when idle and the output slot is free or draining
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // commands to the datapath
   assign cmd.tick      = accept && status.is_tick;
   assign cmd.write     = accept && !status.is_tick;
   assign cmd.div_start = (state_ff == ST_START);
   assign cmd.step_load = (state_ff == ST_DIVIDE) && status.div_done;

   // next state
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.tick) begin
         rsp_valid_in = 1'b1;
      end
      case (state_ff)
         ST_IDLE: begin
            if (cmd.write && status.needs_div) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* hw/rtl/psg_tone_noise_generator.sv */
// top level of the four-channel tone and noise generator
//
// The req channel carries one transaction per command: opcode 0 writes one
// command byte (volume, period low nibble with channel latch, or high six
// period bits of the latched channel), opcode 1 is a sample tick.
// A tick gives one rsp transaction with the four channel samples, valid the
// cycle after acceptance; ticks can follow one per cycle while rsp drains.
// A volume write leaves the block idle. A period write starts a rate/period
// division in the shared restoring divider, one quotient bit per cycle, so
// the block takes no new transaction until the division is done; this divider
// sets the write rate.
// The csr port writes the rate constant and must only be used while idle.
// A stalled rsp holds its samples; a further tick waits until the held
// result is taken in the same or an earlier cycle.
// Synchronous reset clears all channel state, sets the rate constant to its
// default and leaves the block idle with no result pending.
module psg_tone_noise_generator
   import psg_pkg::*;
#(
   parameter int PHASE_BITS = 29
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_payload,
   input  logic              csr_wr_en,
   input  logic [RATE_W-1:0] csr_wr_data
);

`include "psg_tone_noise_generator_assert.svh"

   psg_cmd_type    cmd;
   psg_status_type status;

   // sequencing
   psg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // channel state and arithmetic
   psg_datapath #(
      .PHASE_BITS (PHASE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   // checks
   `PSG_ASSERT_SAME(a_load_not_with_tick, clock, reset, cmd.step_load, !cmd.tick && !cmd.write)
   `PSG_ASSERT_NEXT(a_period_write_busy, clock, reset, cmd.write && status.needs_div, !req_ready)
   `PSG_ASSERT_NEXT(a_tick_gives_result, clock, reset, cmd.tick, rsp_valid)

endmodule

/* test/testbench.sv */
// self-checking testbench for the four-channel tone and noise generator
module testbench;
   import psg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_BITS   = 29;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;
   localparam int WHITE_BIT    = 2;

   // command byte forms
   localparam logic LATCH_FORM = 1'b1;
   localparam logic DATA_FORM  = 1'b0;
   localparam logic VOLUME_REG = 1'b1;
   localparam logic PERIOD_REG = 1'b0;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_payload;
   logic              csr_wr_en = 1'b0;
   logic [RATE_W-1:0] csr_wr_data = '0;

   // predictor state
   logic [RATE_W-1:0]     m_rate;
   logic [7:0]            m_level [4];
   logic [3:0]            m_period_lo [4];
   logic [5:0]            m_period_hi [4];
   logic [PHASE_BITS-1:0] m_accum [4];
   logic [31:0]           m_step [4];
   logic [NOISE_W-1:0]    m_lfsr;
   logic [1:0]            m_latch;

   rsp_type expected_samples [$];

   int error_count     = 0;
   int results_checked = 0;
   int commands_sent   = 0;
   int rate_settings   = 0;
   int cycle_count     = 0;
   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   int hold_cycles     = 0;

   psg_tone_noise_generator #(
      .PHASE_BITS(PHASE_BITS)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("psg_tone_noise_generator test failed");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch: %s, got %0h, expected %0h", what, got, want);
      error_count++;
   endtask

   // compare each accepted result with the oldest expected one
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            report_mismatch("result with nothing expected", rsp_payload, '0);
         end else begin
            want = expected_samples.pop_front();
            if (rsp_payload.tone0_sample !== want.tone0_sample)
               report_mismatch("tone0_sample", 32'(rsp_payload.tone0_sample),
                               32'(want.tone0_sample));
            if (rsp_payload.tone1_sample !== want.tone1_sample)
               report_mismatch("tone1_sample", 32'(rsp_payload.tone1_sample),
                               32'(want.tone1_sample));
            if (rsp_payload.tone2_sample !== want.tone2_sample)
               report_mismatch("tone2_sample", 32'(rsp_payload.tone2_sample),
                               32'(want.tone2_sample));
            if (rsp_payload.noise_sample !== want.noise_sample)
               report_mismatch("noise_sample", 32'(rsp_payload.noise_sample),
                               32'(want.noise_sample));
            results_checked++;
         end
      end
   end

   function automatic void clear_model();
      m_rate  = RATE_RESET;
      m_lfsr  = '0;
      m_latch = '0;
      for (int i = 0; i < 4; i++) begin
         m_level[i]     = '0;
         m_period_lo[i] = '0;
         m_period_hi[i] = '0;
         m_accum[i]     = '0;
         m_step[i]      = '0;
      end
   endfunction

   function automatic logic [31:0] step_for_period(input logic [PERIOD_W-1:0] period);
      if (period == '0)
         return '0;
      return m_rate / {{(32-PERIOD_W){1'b0}}, period};
   endfunction

   function automatic logic [PERIOD_W-1:0] tone_period_of(input logic [1:0] ch);
      return {m_period_hi[ch], m_period_lo[ch]};
   endfunction

   // recompute a channel's step after a period change
   function automatic void refresh_step(input logic [1:0] ch);
      logic                follow;
      logic [PERIOD_W-1:0] period;
      follow = (m_period_lo[NOISE_CH][1:0] == NOISE_RATE_FOLLOW);
      if (ch != NOISE_CH) begin
         m_step[ch] = step_for_period(tone_period_of(ch));
         if (ch == TONE2_CH && follow)
            m_step[NOISE_CH] = m_step[TONE2_CH];
      end else begin
         case (m_period_lo[NOISE_CH][1:0])
            NOISE_RATE_16: period = NOISE_PERIOD_16;
            NOISE_RATE_32: period = NOISE_PERIOD_32;
            NOISE_RATE_64: period = NOISE_PERIOD_64;
            default:       period = tone_period_of(TONE2_CH);
         endcase
         m_step[NOISE_CH] = step_for_period(period);
         m_lfsr = NOISE_RELOAD;
      end
   endfunction

   // apply one accepted transaction; a tick queues its four samples
   function automatic void advance_model(input req_type item);
      logic [7:0]         cmd;
      logic [7:0]         atten;
      logic [1:0]         ch;
      logic [32:0]        sum;
      logic [NOISE_W-1:0] shift;
      logic               feedback;
      logic [7:0]         tone_out [3];
      rsp_type            out;
      cmd = item.command_byte;
      if (item.opcode == OP_WRITE) begin
         if (cmd[7] == LATCH_FORM) begin
            ch = cmd[6:5];
            if (cmd[4] == VOLUME_REG) begin
               atten = {4'd0, cmd[3:0]};
               m_level[ch] = (8'd15 - atten) * 8'h11;
            end else begin
               m_latch = ch;
               m_period_lo[ch] = cmd[3:0];
               refresh_step(ch);
            end
         end else begin
            m_period_hi[m_latch] = cmd[5:0];
            refresh_step(m_latch);
         end
      end else begin
         for (int i = 0; i < 3; i++) begin
            sum = {{(33-PHASE_BITS){1'b0}}, m_accum[i]} + {1'b0, m_step[i]};
            m_accum[i]  = sum[PHASE_BITS-1:0];
            tone_out[i] = m_accum[i][PHASE_BITS-1] ? m_level[i] : 8'd0;
         end
         if (item.frame_start && m_lfsr == '0)
            m_lfsr = NOISE_RELOAD;
         sum = {{(33-PHASE_BITS){1'b0}}, m_accum[NOISE_CH]} + {1'b0, m_step[NOISE_CH]};
         // overflow clocks the noise register once
         if (sum[32:PHASE_BITS] != '0) begin
            shift = m_lfsr;
            if (m_period_lo[NOISE_CH][WHITE_BIT])
               feedback = shift[0] ^ shift[2];
            else
               feedback = ~shift[0];
            shift[5] = shift[5] | feedback;
            m_lfsr = {1'b0, shift[5:1]};
         end
         m_accum[NOISE_CH] = sum[PHASE_BITS-1:0];
         out.tone0_sample = tone_out[0];
         out.tone1_sample = tone_out[1];
         out.tone2_sample = tone_out[2];
         out.noise_sample = m_lfsr[0] ? m_level[NOISE_CH] : 8'd0;
         expected_samples.push_back(out);
      end
   endfunction

   // command and transaction builders
   function automatic logic [7:0] cmd_volume(input logic [1:0] ch, input logic [3:0] atten);
      return {LATCH_FORM, ch, VOLUME_REG, atten};
   endfunction

   function automatic logic [7:0] cmd_period_lo(input logic [1:0] ch, input logic [3:0] nib);
      return {LATCH_FORM, ch, PERIOD_REG, nib};
   endfunction

   function automatic logic [7:0] cmd_period_hi(input logic [5:0] bits);
      return {DATA_FORM, 1'($urandom_range(1)), bits};
   endfunction

   function automatic logic [7:0] cmd_noise(input logic white, input logic [1:0] rate);
      return cmd_period_lo(NOISE_CH, {1'($urandom_range(1)), white, rate});
   endfunction

   function automatic req_type write_item(input logic [7:0] cmd);
      req_type item;
      item.opcode       = OP_WRITE;
      item.command_byte = cmd;
      item.frame_start  = 1'($urandom_range(1));
      return item;
   endfunction

   function automatic req_type tick_item(input logic frame);
      req_type item;
      item.opcode       = OP_TICK;
      item.command_byte = 8'($urandom_range(255));
      item.frame_start  = frame;
      return item;
   endfunction

   // offer one transaction, with a random idle gap first, and wait for it to go in
   task automatic send_command(input req_type item);
      int gap;
      gap = 0;
      while (gap < 60 && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      advance_model(item);
      commands_sent++;
   endtask

   // drop valid, let every expected result arrive, then let a divide finish
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_rate(input logic [RATE_W-1:0] value);
      wait_for_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      m_rate = value;
      rate_settings++;
   endtask

   // register corners, every command form and the noise special cases
   task automatic test_directed();
      send_idle_pct  = 0;
      recv_stall_pct <= 0;
      // volume extremes
      send_command(write_item(cmd_volume(2'd0, 4'h0)));
      send_command(write_item(cmd_volume(2'd1, 4'hf)));
      send_command(write_item(cmd_volume(TONE2_CH, 4'h7)));
      send_command(write_item(cmd_volume(NOISE_CH, 4'h0)));
      // zero noise register stays without a frame start, reloads with one
      send_command(tick_item(1'b0));
      send_command(tick_item(1'b1));
      // zero period holds channel still
      send_command(write_item(cmd_period_lo(2'd0, 4'h0)));
      send_command(write_item(cmd_period_hi(6'h00)));
      // largest and smallest periods
      send_command(write_item(cmd_period_lo(2'd1, 4'hf)));
      send_command(write_item(cmd_period_hi(6'h3f)));
      send_command(write_item(cmd_period_lo(TONE2_CH, 4'h1)));
      send_command(write_item(cmd_period_hi(6'h00)));
      // fixed noise rates, periodic and white
      send_command(write_item(cmd_noise(1'b0, NOISE_RATE_16)));
      send_command(tick_item(1'b0));
      send_command(write_item(cmd_noise(1'b1, NOISE_RATE_32)));
      send_command(write_item(cmd_noise(1'b1, NOISE_RATE_64)));
      // noise following tone 2, high bits on the noise channel reload it
      send_command(write_item(cmd_noise(1'b1, NOISE_RATE_FOLLOW)));
      send_command(write_item(cmd_period_hi(6'h15)));
      // tone 2 change drags the noise step along
      send_command(write_item(cmd_period_lo(TONE2_CH, 4'h5)));
      send_command(write_item(cmd_period_hi(6'h20)));
      repeat (4) send_command(tick_item(1'($urandom_range(1))));
      wait_for_idle();
   endtask

   // mostly well-formed command sequences mixed with ticks and stray bytes
   task automatic test_random_traffic(input int count, input int send_pct,
                                      input int stall_pct);
      int sent;
      int pick;
      sent = 0;
      send_idle_pct  = send_pct;
      recv_stall_pct <= stall_pct;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            send_command(tick_item($urandom_range(15) == 0));
            sent++;
         end else if (pick < 72) begin
            send_command(write_item(cmd_volume(2'($urandom_range(3)),
                                               4'($urandom_range(15)))));
            sent++;
         end else if (pick < 88) begin
            send_command(write_item(cmd_period_lo(2'($urandom_range(3)),
                                                  4'($urandom_range(15)))));
            send_command(write_item(cmd_period_hi(6'($urandom_range(63)))));
            sent += 2;
         end else if (pick < 93) begin
            send_command(write_item(cmd_period_hi(6'($urandom_range(63)))));
            sent++;
         end else begin
            send_command(write_item(8'($urandom_range(255))));
            sent++;
         end
      end
      wait_for_idle();
   endtask

   // long receiver hold-off while ticks keep coming, so the input backs up
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct <= 0;
      hold_cycles    <= HOLD_CYCLES;
      repeat (8) send_command(tick_item(1'b0));
      wait_for_idle();
   endtask

   initial begin
      clear_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_traffic(300, 0, 0);
      write_rate(32'hffff_ffff);
      test_random_traffic(250, 78, 0);
      write_rate(32'h0000_0000);
      test_random_traffic(80, 0, 78);
      write_rate(32'($urandom));
      test_random_traffic(250, 25, 25);
      test_backpressure();
      write_rate(RATE_RESET);
      test_random_traffic(250, 0, 0);
      wait_for_idle();

      $display("run covered %0d commands and %0d checked sample ticks", commands_sent,
               results_checked);
      $display("over %0d rate settings, four idling mixes and one long receiver hold-off",
               rate_settings + 1);
      if (error_count == 0) begin
         $display("psg_tone_noise_generator test passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("psg_tone_noise_generator test failed");
      end
      $finish;
   end

endmodule
